FILE: rtl/rounded_rect_radii_constrain_core_defines.svh
// Assertion macros shared by the radii constraint RTL.
`ifndef ROUNDED_RECT_RADII_CONSTRAIN_CORE_DEFINES_SVH
`define ROUNDED_RECT_RADII_CONSTRAIN_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Whenever the antecedent holds, the consequent holds in the same cycle.
`define RRRC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rrrc assertion failed");
// In the cycle after reset is seen, the consequent holds.
`define RRRC_ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("rrrc reset assertion failed");
`else
`define RRRC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define RRRC_ASSERT_AFTER_RESET(label, clk, rst, cons)
`endif
`endif

FILE: rtl/rrrc_pkg.sv
// Package with shared constants and types of the radii constraint core.
`default_nettype none
package rrrc_pkg;
   localparam int LENGTH_BITS_DEFAULT      = 24;
   localparam int FACTOR_FRAC_BITS_DEFAULT = 20;
   localparam int QUEUE_DEPTH_DEFAULT      = 4;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;
endpackage
`default_nettype wire

FILE: rtl/rrrc_if.sv
// Channel interfaces for request and response transactions.
`default_nettype none
interface rrrc_req_if #(
   parameter int LENGTH_BITS = rrrc_pkg::LENGTH_BITS_DEFAULT
) ();
   logic                   valid;
   logic                   ready;
   logic [LENGTH_BITS-1:0] rect_width;
   logic [LENGTH_BITS-1:0] rect_height;
   logic [LENGTH_BITS-1:0] tl_horiz;
   logic [LENGTH_BITS-1:0] tl_vert;
   logic [LENGTH_BITS-1:0] tr_horiz;
   logic [LENGTH_BITS-1:0] tr_vert;
   logic [LENGTH_BITS-1:0] bl_horiz;
   logic [LENGTH_BITS-1:0] bl_vert;
   logic [LENGTH_BITS-1:0] br_horiz;
   logic [LENGTH_BITS-1:0] br_vert;

   modport source (output valid, rect_width, rect_height, tl_horiz, tl_vert, tr_horiz,
                   tr_vert, bl_horiz, bl_vert, br_horiz, br_vert, input ready);
   modport sink (input valid, rect_width, rect_height, tl_horiz, tl_vert, tr_horiz,
                 tr_vert, bl_horiz, bl_vert, br_horiz, br_vert, output ready);
endinterface

interface rrrc_rsp_if #(
   parameter int LENGTH_BITS      = rrrc_pkg::LENGTH_BITS_DEFAULT,
   parameter int FACTOR_FRAC_BITS = rrrc_pkg::FACTOR_FRAC_BITS_DEFAULT
) ();
   logic                      valid;
   logic                      ready;
   logic [LENGTH_BITS-1:0]    out_tl_horiz;
   logic [LENGTH_BITS-1:0]    out_tl_vert;
   logic [LENGTH_BITS-1:0]    out_tr_horiz;
   logic [LENGTH_BITS-1:0]    out_tr_vert;
   logic [LENGTH_BITS-1:0]    out_bl_horiz;
   logic [LENGTH_BITS-1:0]    out_bl_vert;
   logic [LENGTH_BITS-1:0]    out_br_horiz;
   logic [LENGTH_BITS-1:0]    out_br_vert;
   logic [FACTOR_FRAC_BITS:0] scale_factor;

   modport source (output valid, out_tl_horiz, out_tl_vert, out_tr_horiz, out_tr_vert,
                   out_bl_horiz, out_bl_vert, out_br_horiz, out_br_vert, scale_factor,
                   input ready);
   modport sink (input valid, out_tl_horiz, out_tl_vert, out_tr_horiz, out_tr_vert,
                 out_bl_horiz, out_bl_vert, out_br_horiz, out_br_vert, scale_factor,
                 output ready);
endinterface
`default_nettype wire

FILE: rtl/rrrc_queue.sv
// Small register queue between the front and back parts.
`default_nettype none
module rrrc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = rrrc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          head_data,
   output rrrc_pkg::queue_status_type q_stat
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             push_ok, pop_ok;

   assign q_stat.full  = (cnt_ff == CW'(DEPTH));
   assign q_stat.empty = (cnt_ff == '0);
   assign push_ok      = push && !q_stat.full;
   assign pop_ok       = pop && !q_stat.empty;
   assign head_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/rrrc_front.sv
// Front part: accepts requests and forms the edge radius sums.
`default_nettype none
module rrrc_front #(
   parameter int LENGTH_BITS = rrrc_pkg::LENGTH_BITS_DEFAULT,
   parameter int QW          = 12 * LENGTH_BITS + 2
) (
   input  logic                       clock,
   input  logic                       reset,
   rrrc_req_if.sink                   req_chan,
   input  rrrc_pkg::queue_status_type q_stat,
   output logic                       push,
   output logic [QW-1:0]              push_data
);
   localparam int L = LENGTH_BITS;

   logic         vld_ff, vld_in;
   logic [L:0]   hsum_ff, hsum_in;
   logic [L:0]   vsum_ff, vsum_in;
   logic [L-1:0] w_ff, h_ff;
   logic [8*L-1:0] radii_ff, radii_in;
   logic [L:0]   top, bot, lft, rgt;
   logic         accept;

   assign req_chan.ready = !vld_ff || !q_stat.full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign push           = vld_ff && !q_stat.full;
   assign push_data      = {hsum_ff, vsum_ff, w_ff, h_ff, radii_ff};

   always_comb begin
      top      = {1'b0, req_chan.tl_horiz} + {1'b0, req_chan.tr_horiz};
      bot      = {1'b0, req_chan.bl_horiz} + {1'b0, req_chan.br_horiz};
      lft      = {1'b0, req_chan.tl_vert} + {1'b0, req_chan.bl_vert};
      rgt      = {1'b0, req_chan.tr_vert} + {1'b0, req_chan.br_vert};
      hsum_in  = (top > bot) ? top : bot;
      vsum_in  = (lft > rgt) ? lft : rgt;
      radii_in = {req_chan.br_vert, req_chan.br_horiz, req_chan.bl_vert, req_chan.bl_horiz,
                  req_chan.tr_vert, req_chan.tr_horiz, req_chan.tl_vert, req_chan.tl_horiz};
      vld_in   = accept ? 1'b1 : (push ? 1'b0 : vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hsum_ff  <= hsum_in;
         vsum_ff  <= vsum_in;
         w_ff     <= req_chan.rect_width;
         h_ff     <= req_chan.rect_height;
         radii_ff <= radii_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/rrrc_back.sv
// Back part: bit-per-stage dividers, factor select, scaling and corner clearing.
`default_nettype none
module rrrc_back #(
   parameter int LENGTH_BITS      = rrrc_pkg::LENGTH_BITS_DEFAULT,
   parameter int FACTOR_FRAC_BITS = rrrc_pkg::FACTOR_FRAC_BITS_DEFAULT,
   parameter int QW               = 12 * LENGTH_BITS + 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [QW-1:0]              head_data,
   input  rrrc_pkg::queue_status_type q_stat,
   output logic                       pop,
   rrrc_rsp_if.source                 rsp_chan
);
   localparam int L  = LENGTH_BITS;
   localparam int F  = FACTOR_FRAC_BITS;
   localparam int RW = 8 * L;
   localparam int PW = L + F + 1;

   // Head fields.
   logic [L:0]    head_hsum, head_vsum;
   logic [L-1:0]  head_w, head_h;
   logic [RW-1:0] head_radii;

   // Divider stages: stage 0 is loaded from the queue, stage k has k quotient bits.
   logic          vld_ff    [0:F];
   logic          vld_in    [0:F];
   logic [L:0]    rem_w_ff  [0:F];
   logic [L:0]    rem_w_in  [0:F];
   logic [L:0]    rem_h_ff  [0:F];
   logic [L:0]    rem_h_in  [0:F];
   logic [L:0]    div_w_ff  [0:F];
   logic [L:0]    div_w_in  [0:F];
   logic [L:0]    div_h_ff  [0:F];
   logic [L:0]    div_h_in  [0:F];
   logic [F-1:0]  quo_w_ff  [0:F];
   logic [F-1:0]  quo_w_in  [0:F];
   logic [F-1:0]  quo_h_ff  [0:F];
   logic [F-1:0]  quo_h_in  [0:F];
   logic          need_w_ff [0:F];
   logic          need_w_in [0:F];
   logic          need_h_ff [0:F];
   logic          need_h_in [0:F];
   logic [RW-1:0] radii_ff  [0:F];
   logic [RW-1:0] radii_in  [0:F];

   // Factor, multiply and output stages.
   logic          fvld_ff, mvld_ff, ovld_ff;
   logic [F:0]    fac_ff, fac_in;
   logic [RW-1:0] fradii_ff;
   logic [F:0]    mfac_ff;
   logic [RW-1:0] scaled_ff, scaled_in;
   logic [F:0]    ofac_ff;
   logic [RW-1:0] oradii_ff, oradii_in;
   logic [L+1:0]  t_w, t_h;
   logic          ge_w, ge_h;
   logic [PW-1:0] prod;
   logic          adv;

   assign {head_hsum, head_vsum, head_w, head_h, head_radii} = head_data;
   assign adv = !ovld_ff || rsp_chan.ready;
   assign pop = adv && !q_stat.empty;

   always_comb begin
      t_w  = '0;
      t_h  = '0;
      ge_w = 1'b0;
      ge_h = 1'b0;
      vld_in[0]    = !q_stat.empty;
      rem_w_in[0]  = {1'b0, head_w};
      rem_h_in[0]  = {1'b0, head_h};
      div_w_in[0]  = head_hsum;
      div_h_in[0]  = head_vsum;
      quo_w_in[0]  = '0;
      quo_h_in[0]  = '0;
      need_w_in[0] = head_hsum > {1'b0, head_w};
      need_h_in[0] = head_vsum > {1'b0, head_h};
      radii_in[0]  = head_radii;
      for (int k = 1; k <= F; k++) begin
         t_w  = {rem_w_ff[k-1], 1'b0};
         t_h  = {rem_h_ff[k-1], 1'b0};
         ge_w = t_w >= {1'b0, div_w_ff[k-1]};
         ge_h = t_h >= {1'b0, div_h_ff[k-1]};
         rem_w_in[k]  = ge_w ? (t_w[L:0] - div_w_ff[k-1]) : t_w[L:0];
         rem_h_in[k]  = ge_h ? (t_h[L:0] - div_h_ff[k-1]) : t_h[L:0];
         quo_w_in[k]  = {quo_w_ff[k-1][F-2:0], ge_w};
         quo_h_in[k]  = {quo_h_ff[k-1][F-2:0], ge_h};
         vld_in[k]    = vld_ff[k-1];
         div_w_in[k]  = div_w_ff[k-1];
         div_h_in[k]  = div_h_ff[k-1];
         need_w_in[k] = need_w_ff[k-1];
         need_h_in[k] = need_h_ff[k-1];
         radii_in[k]  = radii_ff[k-1];
      end
   end

   // A side constrains the factor only when its sum exceeds the side length.
   always_comb begin
      fac_in = {1'b1, {F{1'b0}}};
      if (need_w_ff[F] && ({1'b0, quo_w_ff[F]} < fac_in)) begin
         fac_in = {1'b0, quo_w_ff[F]};
      end
      if (need_h_ff[F] && ({1'b0, quo_h_ff[F]} < fac_in)) begin
         fac_in = {1'b0, quo_h_ff[F]};
      end
   end

   always_comb begin
      prod = '0;
      for (int i = 0; i < 8; i++) begin
         prod = fradii_ff[i*L +: L] * fac_ff;
         scaled_in[i*L +: L] = prod[F +: L];
      end
   end

   // Below one, a corner with a zero component is flattened entirely.
   always_comb begin
      oradii_in = scaled_ff;
      for (int c = 0; c < 4; c++) begin
         if (!mfac_ff[F] && ((scaled_ff[2*c*L +: L] == '0) ||
                             (scaled_ff[(2*c+1)*L +: L] == '0))) begin
            oradii_in[2*c*L +: 2*L] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= F; k++) begin
            vld_ff[k] <= 1'b0;
         end
         fvld_ff <= 1'b0;
         mvld_ff <= 1'b0;
         ovld_ff <= 1'b0;
      end else if (adv) begin
         for (int k = 0; k <= F; k++) begin
            vld_ff[k] <= vld_in[k];
         end
         fvld_ff <= vld_ff[F];
         mvld_ff <= fvld_ff;
         ovld_ff <= mvld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= F; k++) begin
            rem_w_ff[k]  <= rem_w_in[k];
            rem_h_ff[k]  <= rem_h_in[k];
            div_w_ff[k]  <= div_w_in[k];
            div_h_ff[k]  <= div_h_in[k];
            quo_w_ff[k]  <= quo_w_in[k];
            quo_h_ff[k]  <= quo_h_in[k];
            need_w_ff[k] <= need_w_in[k];
            need_h_ff[k] <= need_h_in[k];
            radii_ff[k]  <= radii_in[k];
         end
         fac_ff    <= fac_in;
         fradii_ff <= radii_ff[F];
         mfac_ff   <= fac_ff;
         scaled_ff <= scaled_in;
         ofac_ff   <= mfac_ff;
         oradii_ff <= oradii_in;
      end
   end

   assign rsp_chan.valid        = ovld_ff;
   assign rsp_chan.out_tl_horiz = oradii_ff[0*L +: L];
   assign rsp_chan.out_tl_vert  = oradii_ff[1*L +: L];
   assign rsp_chan.out_tr_horiz = oradii_ff[2*L +: L];
   assign rsp_chan.out_tr_vert  = oradii_ff[3*L +: L];
   assign rsp_chan.out_bl_horiz = oradii_ff[4*L +: L];
   assign rsp_chan.out_bl_vert  = oradii_ff[5*L +: L];
   assign rsp_chan.out_br_horiz = oradii_ff[6*L +: L];
   assign rsp_chan.out_br_vert  = oradii_ff[7*L +: L];
   assign rsp_chan.scale_factor = ofac_ff;
endmodule
`default_nettype wire

FILE: rtl/rounded_rect_radii_constrain_core.sv
// Top level of the rounded rectangle corner radii constraint core.
//
//   Channel   Direction  Handshake     Payload
//   req_chan  in         valid/ready   rect size and four corner radii (16.8 each)
//   rsp_chan  out        valid/ready   scaled radii and the applied scale factor
//
// One transaction is accepted per cycle while the queue has room; the pipeline is fully overlapped.
// The divider resolves one quotient bit per stage for the width and height ratios.
// Reset is synchronous and clears only the valid, pointer and count state.
// A stalled response holds the back pipeline; the queue keeps taking requests
// until its QUEUE_DEPTH entries are full, and then req_chan.ready drops.
`default_nettype none
`include "rounded_rect_radii_constrain_core_defines.svh"
module rounded_rect_radii_constrain_core #(
   parameter int LENGTH_BITS      = rrrc_pkg::LENGTH_BITS_DEFAULT,
   parameter int FACTOR_FRAC_BITS = rrrc_pkg::FACTOR_FRAC_BITS_DEFAULT,
   parameter int QUEUE_DEPTH      = rrrc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   rrrc_req_if.sink    req_chan,
   rrrc_rsp_if.source  rsp_chan
);
   // Queue word: both edge sums, the rectangle size and all eight radii.
   localparam int QW = 12 * LENGTH_BITS + 2;

   logic                       push;
   logic [QW-1:0]              push_data;
   logic                       pop;
   logic [QW-1:0]              head_data;
   rrrc_pkg::queue_status_type q_stat;

   // The front part sums the radii along each edge and keeps the larger per axis.
   rrrc_front #(
      .LENGTH_BITS (LENGTH_BITS),
      .QW          (QW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .q_stat    (q_stat),
      .push      (push),
      .push_data (push_data)
   );

   // The queue lets requests keep flowing while the response side stalls.
   rrrc_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .q_stat    (q_stat)
   );

   // The back part divides, picks the factor, scales and clears flat corners.
   rrrc_back #(
      .LENGTH_BITS      (LENGTH_BITS),
      .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS),
      .QW               (QW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_data (head_data),
      .q_stat    (q_stat),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

   // The factor never exceeds one.
   `RRRC_ASSERT_IMPLIES(a_factor_at_most_one, clock, reset, rsp_chan.valid && rsp_chan.scale_factor[FACTOR_FRAC_BITS], rsp_chan.scale_factor[FACTOR_FRAC_BITS-1:0] == '0)
   // Below one, a top left corner with a zero horizontal radius is fully cleared.
   `RRRC_ASSERT_IMPLIES(a_corner_cleared, clock, reset, rsp_chan.valid && !rsp_chan.scale_factor[FACTOR_FRAC_BITS] && (rsp_chan.out_tl_horiz == '0), rsp_chan.out_tl_vert == '0)
   // A zero factor flattens every radius; the check samples three of them.
   `RRRC_ASSERT_IMPLIES(a_zero_factor_flat, clock, reset, rsp_chan.valid && (rsp_chan.scale_factor == '0), (rsp_chan.out_tr_horiz == '0) && (rsp_chan.out_br_vert == '0) && (rsp_chan.out_bl_horiz == '0))
   // No response is offered right after reset.
   `RRRC_ASSERT_AFTER_RESET(a_reset_clears_rsp, clock, reset, !rsp_chan.valid)
endmodule
`default_nettype wire

FILE: test/rounded_rect_radii_constrain_core_tb.sv
// Self-checking testbench for the rounded rectangle corner radii constraint core.
`default_nettype none
module rounded_rect_radii_constrain_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          LB          = rrrc_pkg::LENGTH_BITS_DEFAULT;
   localparam int          FB          = rrrc_pkg::FACTOR_FRAC_BITS_DEFAULT;

   typedef logic [LB-1:0] length_type;
   typedef logic [FB:0]   factor_type;

   localparam length_type  LEN_MAX     = '1;
   localparam length_type  HALF_LEN    = LEN_MAX >> 1;
   localparam factor_type  FACTOR_ONE  = factor_type'(1) << FB;
   localparam factor_type  FACTOR_HALF = FACTOR_ONE >> 1;
   // Pipeline depth of the core, plus a margin for the drain.
   localparam int          DRAIN_CYCLES  = FB + 6 + 10;
   localparam int          PHASE_ITEMS   = 283;
   localparam int          HOLD_CYCLES   = 80;
   localparam int          PRINT_LIMIT   = 60;
   localparam int          DIRECTED_ROWS = 19;

   // One request transaction: the rectangle and its four corner radii.
   typedef struct packed {
      length_type rect_width;
      length_type rect_height;
      length_type tl_horiz;
      length_type tl_vert;
      length_type tr_horiz;
      length_type tr_vert;
      length_type bl_horiz;
      length_type bl_vert;
      length_type br_horiz;
      length_type br_vert;
   } rect_shape_type;

   // One response transaction: the scaled radii and the factor that was applied.
   typedef struct packed {
      length_type tl_horiz;
      length_type tl_vert;
      length_type tr_horiz;
      length_type tr_vert;
      length_type bl_horiz;
      length_type bl_vert;
      length_type br_horiz;
      length_type br_vert;
      factor_type scale_factor;
   } scaled_radii_type;

   // A row of the directed table. Where has_result is set, the expected response is
   // written into the row; otherwise the predictor supplies it.
   typedef struct {
      rect_shape_type   shape;
      bit               has_result;
      scaled_radii_type result;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;

   rrrc_req_if req_chan ();
   rrrc_rsp_if rsp_chan ();

   rounded_rect_radii_constrain_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Responses still owed by the core, oldest first.
   scaled_radii_type pending_results [$];
   int               mismatch_count = 0;

   // Percentages of cycles in which the sender idles and the receiver stalls.
   int               send_idle_pct  = 0;
   int               rsp_stall_pct  = 0;
   // Forces the receiver to hold off while set.
   logic             hold_rsp       = 1'b0;

   directed_row_type directed_table [DIRECTED_ROWS];

   always #5 clock = ~clock;

   function automatic rect_shape_type mk_shape(
      input length_type w, input length_type h,
      input length_type tlh, input length_type tlv, input length_type trh,
      input length_type trv, input length_type blh, input length_type blv,
      input length_type brh, input length_type brv);
      return '{w, h, tlh, tlv, trh, trv, blh, blv, brh, brv};
   endfunction

   function automatic scaled_radii_type mk_result(
      input length_type tlh, input length_type tlv, input length_type trh,
      input length_type trv, input length_type blh, input length_type blv,
      input length_type brh, input length_type brv, input factor_type factor);
      return '{tlh, tlv, trh, trv, blh, blv, brh, brv, factor};
   endfunction

   // Works out the response for one rectangle. The factor starts at one and each
   // side whose radius sum exceeds the side length pulls the factor down to side / sum,
   // truncated. Only a factor below one touches the radii: each component is
   // scaled with truncation, and a corner left with a zero component is cleared.
   function automatic scaled_radii_type constrain_radii(input rect_shape_type s);
      longint unsigned  rad [8];
      longint unsigned  horiz_sum, vert_sum, factor, quot;
      scaled_radii_type res;
      int               i;
      rad[0] = s.tl_horiz;
      rad[1] = s.tl_vert;
      rad[2] = s.tr_horiz;
      rad[3] = s.tr_vert;
      rad[4] = s.bl_horiz;
      rad[5] = s.bl_vert;
      rad[6] = s.br_horiz;
      rad[7] = s.br_vert;
      // Top against bottom edge, left against right edge.
      horiz_sum = (rad[0] + rad[2] > rad[4] + rad[6]) ? rad[0] + rad[2] : rad[4] + rad[6];
      vert_sum  = (rad[1] + rad[5] > rad[3] + rad[7]) ? rad[1] + rad[5] : rad[3] + rad[7];
      factor = FACTOR_ONE;
      if (horiz_sum > s.rect_width) begin
         quot = (longint'(s.rect_width) << FB) / horiz_sum;
         if (quot < factor) factor = quot;
      end
      if (vert_sum > s.rect_height) begin
         quot = (longint'(s.rect_height) << FB) / vert_sum;
         if (quot < factor) factor = quot;
      end
      if (factor != FACTOR_ONE) begin
         for (i = 0; i < 8; i++) rad[i] = (rad[i] * factor) >> FB;
         for (i = 0; i < 8; i += 2) begin
            if (rad[i] == 0 || rad[i+1] == 0) begin
               rad[i]   = 0;
               rad[i+1] = 0;
            end
         end
      end
      res.tl_horiz     = rad[0][LB-1:0];
      res.tl_vert      = rad[1][LB-1:0];
      res.tr_horiz     = rad[2][LB-1:0];
      res.tr_vert      = rad[3][LB-1:0];
      res.bl_horiz     = rad[4][LB-1:0];
      res.bl_vert      = rad[5][LB-1:0];
      res.br_horiz     = rad[6][LB-1:0];
      res.br_vert      = rad[7][LB-1:0];
      res.scale_factor = factor[FB:0];
      return res;
   endfunction

   // Random rectangle. The mix favors shapes that land on interesting paths: radii
   // that fit, sums right at a side, tiny sides, corners that scale down to zero,
   // zero sides, and sparse or dense bit patterns.
   function automatic rect_shape_type random_shape();
      length_type  f [10];
      longint      need [2];
      longint      side;
      int unsigned pick;
      int          i;
      pick = $urandom_range(9);
      // f: width, height, then tl, tr, bl, br as horizontal/vertical pairs.
      for (i = 0; i < 10; i++) f[i] = length_type'($urandom());
      case (pick)
         2, 7: begin
            for (i = 2; i < 10; i++) f[i] = length_type'($urandom_range(HALF_LEN));
            need[0] = (f[2] + 64'(f[4]) > f[6] + 64'(f[8])) ? f[2] + 64'(f[4])
                                                            : f[6] + 64'(f[8]);
            need[1] = (f[3] + 64'(f[7]) > f[5] + 64'(f[9])) ? f[3] + 64'(f[7])
                                                            : f[5] + 64'(f[9]);
            for (i = 0; i < 2; i++) begin
               if (pick == 2) begin
                  side = need[i] + $urandom_range(LEN_MAX - int'(need[i]));
               end else begin
                  // Exactly at the sum, or one step to either side of it.
                  side = need[i] + longint'($urandom_range(2)) - 1;
               end
               if (side < 0) side = 0;
               if (side > LEN_MAX) side = LEN_MAX;
               f[i] = length_type'(side);
            end
         end
         3: begin
            for (i = 0; i < 10; i++) f[i] = length_type'($urandom_range(1023));
         end
         4: begin
            f[0] = length_type'($urandom_range(255));
            f[1] = length_type'($urandom_range(255));
         end
         5: begin
            f[0] = length_type'($urandom_range(4095));
            f[1] = length_type'($urandom_range(4095));
            for (i = 0; i < 4; i++) begin
               f[2 + 2*i + $urandom_range(1)] = length_type'($urandom_range(3));
            end
         end
         6: begin
            case ($urandom_range(2))
               0: f[0] = '0;
               1: f[1] = '0;
               default: begin
                  f[0] = '0;
                  f[1] = '0;
               end
            endcase
            // Sometimes all horizontal radii are zero, so a zero width must not constrain.
            if ($urandom_range(3) == 0) begin
               for (i = 2; i < 10; i += 2) f[i] = '0;
            end
         end
         8: begin
            for (i = 0; i < 10; i++) f[i] &= length_type'($urandom() & $urandom());
         end
         9: begin
            for (i = 0; i < 10; i++) f[i] |= length_type'($urandom());
         end
         default: ;
      endcase
      return mk_shape(f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9]);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                  want);
      end
      mismatch_count++;
   endtask

   // Compares an accepted response transaction with the oldest expectation.
   task automatic check_response();
      scaled_radii_type got;
      scaled_radii_type want;
      got = '{rsp_chan.out_tl_horiz, rsp_chan.out_tl_vert, rsp_chan.out_tr_horiz,
              rsp_chan.out_tr_vert, rsp_chan.out_bl_horiz, rsp_chan.out_bl_vert,
              rsp_chan.out_br_horiz, rsp_chan.out_br_vert, rsp_chan.scale_factor};
      if (pending_results.size() == 0) begin
         report_mismatch("response with nothing pending, scale_factor", got.scale_factor, 0);
         return;
      end
      want = pending_results.pop_front();
      if (got.tl_horiz !== want.tl_horiz)
         report_mismatch("out_tl_horiz", got.tl_horiz, want.tl_horiz);
      if (got.tl_vert !== want.tl_vert)
         report_mismatch("out_tl_vert", got.tl_vert, want.tl_vert);
      if (got.tr_horiz !== want.tr_horiz)
         report_mismatch("out_tr_horiz", got.tr_horiz, want.tr_horiz);
      if (got.tr_vert !== want.tr_vert)
         report_mismatch("out_tr_vert", got.tr_vert, want.tr_vert);
      if (got.bl_horiz !== want.bl_horiz)
         report_mismatch("out_bl_horiz", got.bl_horiz, want.bl_horiz);
      if (got.bl_vert !== want.bl_vert)
         report_mismatch("out_bl_vert", got.bl_vert, want.bl_vert);
      if (got.br_horiz !== want.br_horiz)
         report_mismatch("out_br_horiz", got.br_horiz, want.br_horiz);
      if (got.br_vert !== want.br_vert)
         report_mismatch("out_br_vert", got.br_vert, want.br_vert);
      if (got.scale_factor !== want.scale_factor)
         report_mismatch("scale_factor", got.scale_factor, want.scale_factor);
   endtask

   // Offers one request transaction, idling first at the current rate. Called at a
   // rising edge and returns at the edge where the transaction was accepted, so
   // valid stays high into the next call unless that call decides to idle.
   task automatic offer_shape(input rect_shape_type shape, input scaled_radii_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.rect_width  <= shape.rect_width;
      req_chan.rect_height <= shape.rect_height;
      req_chan.tl_horiz    <= shape.tl_horiz;
      req_chan.tl_vert     <= shape.tl_vert;
      req_chan.tr_horiz    <= shape.tr_horiz;
      req_chan.tr_vert     <= shape.tr_vert;
      req_chan.bl_horiz    <= shape.bl_horiz;
      req_chan.bl_vert     <= shape.bl_vert;
      req_chan.br_horiz    <= shape.br_horiz;
      req_chan.br_vert     <= shape.br_vert;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      pending_results.push_back(want);
   endtask

   // Holds the receiver off for a counted number of cycles, long enough for the
   // pipeline and the input queue to fill so that req_chan.ready must drop.
   task automatic hold_off_receiver(input int cycles);
      hold_rsp <= 1'b1;
      repeat (cycles) @(posedge clock);
      hold_rsp <= 1'b0;
   endtask

   // Receiver: outside reset and hold-off, ready is redrawn every cycle from the current stall rate.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset || hold_rsp) begin
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Every accepted response transaction is checked at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         check_response();
      end
   end

   // Main sequence: reset, the directed table, then four phases of random traffic
   // with different idle and stall rates, then the drain and the verdict.
   initial begin
      int row;
      int phase;
      int n;
      rect_shape_type shape;

      // Directed rows: empty shape, zero sides with radii on them, all-ones fields,
      // sums exactly at a side or one above it, a factor of one with a zero corner
      // component kept, corners that scale to zero and get cleared, each edge
      // dominating in turn, and alternating bit patterns.
      directed_table = '{
         '{mk_shape(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
           mk_result(0, 0, 0, 0, 0, 0, 0, 0, FACTOR_ONE)},
         '{mk_shape(0, LEN_MAX, 1, 0, 0, 0, 0, 0, 0, 0), 1'b1,
           mk_result(0, 0, 0, 0, 0, 0, 0, 0, 0)},
         '{mk_shape(LEN_MAX, 0, 0, 1, 0, 0, 0, 0, 0, 0), 1'b1,
           mk_result(0, 0, 0, 0, 0, 0, 0, 0, 0)},
         '{mk_shape(0, 0, LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX,
                    LEN_MAX), 1'b1,
           mk_result(0, 0, 0, 0, 0, 0, 0, 0, 0)},
         // Every field at its maximum: both sums are twice the side, factor one half.
         '{mk_shape(LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX,
                    LEN_MAX, LEN_MAX), 1'b1,
           mk_result(HALF_LEN, HALF_LEN, HALF_LEN, HALF_LEN, HALF_LEN, HALF_LEN, HALF_LEN,
                     HALF_LEN, FACTOR_HALF)},
         '{mk_shape(LEN_MAX, LEN_MAX, HALF_LEN, HALF_LEN, HALF_LEN, HALF_LEN, HALF_LEN,
                    HALF_LEN, HALF_LEN, HALF_LEN), 1'b1,
           mk_result(HALF_LEN, HALF_LEN, HALF_LEN, HALF_LEN, HALF_LEN, HALF_LEN, HALF_LEN,
                     HALF_LEN, FACTOR_ONE)},
         // Sums exactly equal to the sides do not constrain.
         '{mk_shape('hC800, 'hC800, 'h6400, 'h6400, 'h6400, 'h6400, 'h6400, 'h6400, 'h6400,
                    'h6400), 1'b1,
           mk_result('h6400, 'h6400, 'h6400, 'h6400, 'h6400, 'h6400, 'h6400, 'h6400,
                     FACTOR_ONE)},
         // Factor of one: a corner with a zero component passes through uncleared.
         '{mk_shape('hC800, 'hC800, 'h6400, 0, 'h6400, 'h6400, 'h6400, 'h6400, 'h6400,
                    'h6400), 1'b1,
           mk_result('h6400, 0, 'h6400, 'h6400, 'h6400, 'h6400, 'h6400, 'h6400,
                     FACTOR_ONE)},
         '{mk_shape('hC800, 'hC800, 'h6400, 'h6400, 'h6401, 'h6400, 'h6400, 'h6400, 'h6400,
                    'h6400), 1'b0, '0},
         // Width one, top sum two: everything halves, bottom corners stay empty.
         '{mk_shape('h100, LEN_MAX, 'h100, 'h100, 'h100, 'h100, 0, 0, 0, 0), 1'b1,
           mk_result('h80, 'h80, 'h80, 'h80, 0, 0, 0, 0, FACTOR_HALF)},
         // Smallest lengths: halving leaves zeros, so every corner is cleared.
         '{mk_shape(1, 1, 1, 1, 1, 1, 1, 1, 1, 1), 1'b1,
           mk_result(0, 0, 0, 0, 0, 0, 0, 0, FACTOR_HALF)},
         '{mk_shape(LEN_MAX, 'h1000, 'h100, 'h200, 'h300, 'h400, 'h500, 'hA0000, 'h600,
                    'hF0000), 1'b0, '0},
         '{mk_shape('h2000, 'h800, 'h1000, 'h3000, 'h1800, 'h700, 'h2100, 'h900, 'h400,
                    'h2200), 1'b0, '0},
         '{mk_shape('h100, LEN_MAX, LEN_MAX, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0},
         '{mk_shape(LEN_MAX, LEN_MAX, LEN_MAX, 'h10, 1, 'h20, 'h30, 'h40, 'h50, 'h60),
           1'b0, '0},
         '{mk_shape('hAAAAAA, 'h555555, 'hAAAAAA, 'h555555, 'hAAAAAA, 'h555555, 'hAAAAAA,
                    'h555555, 'hAAAAAA, 'h555555), 1'b0, '0},
         '{mk_shape('h555555, 'hAAAAAA, 'h555555, 'hAAAAAA, 'h555555, 'hAAAAAA, 'h555555,
                    'hAAAAAA, 'h555555, 'hAAAAAA), 1'b0, '0},
         '{mk_shape('h123456, 'h0FEDCB, 'h010000, 'h020000, 'h030000, 'h040000, 'h0A0000,
                    'h050000, 'h0B0000, 'h060000), 1'b0, '0},
         '{mk_shape('h800000, 'h7FFFFF, 'h400000, 'h3FFFFF, 'h400001, 'h400000, 'h3FFFFF,
                    'h400001, 'h400000, 'h3FFFFF), 1'b0, '0}
      };

      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.rect_width  <= '0;
      req_chan.rect_height <= '0;
      req_chan.tl_horiz    <= '0;
      req_chan.tl_vert     <= '0;
      req_chan.tr_horiz    <= '0;
      req_chan.tr_vert     <= '0;
      req_chan.bl_horiz    <= '0;
      req_chan.bl_vert     <= '0;
      req_chan.br_horiz    <= '0;
      req_chan.br_vert     <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         shape = directed_table[row].shape;
         offer_shape(shape, directed_table[row].has_result ? directed_table[row].result
                                                           : constrain_radii(shape));
      end

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct <= 0;
            end
            1: begin
               send_idle_pct = 57;
               rsp_stall_pct <= 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct <= 57;
            end
            default: begin
               send_idle_pct = 34;
               rsp_stall_pct <= 34;
            end
         endcase
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // Back-pressure test: the receiver stops while requests keep coming.
            if (phase == 0 && n == 40) begin
               fork
                  hold_off_receiver(HOLD_CYCLES);
               join_none
            end
            shape = random_shape();
            offer_shape(shape, constrain_radii(shape));
         end
      end

      req_chan.valid <= 1'b0;
      rsp_stall_pct  <= 0;
      while (pending_results.size() != 0) @(posedge clock);
      // Anything arriving after this point has no transaction behind it.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog: a correct run ends within a few tens of microseconds.
   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
`default_nettype wire

FILE: files.f
+incdir+rtl
rtl/rrrc_pkg.sv
rtl/rrrc_if.sv
rtl/rrrc_queue.sv
rtl/rrrc_front.sv
rtl/rrrc_back.sv
rtl/rounded_rect_radii_constrain_core.sv
test/rounded_rect_radii_constrain_core_tb.sv
